[rtl/qbps_pkg.sv]
// qbps_pkg: shared types and constants for the quadratic bezier path stepper
// no dependencies
`timescale 1ns / 1ps
package qbps_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned ProgFracBits = 16;
  localparam int unsigned HalvingCap = 17;
  localparam int unsigned CoordW = 24;
  localparam int unsigned DistW = 48;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_TRAVEL = 2'd1,
    REQ_RESET = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD2,
    ST_END,
    ST_HALVE,
    ST_WSQ,
    ST_W2SQ,
    ST_BX0,
    ST_BX1,
    ST_BX2,
    ST_BY0,
    ST_BY1,
    ST_BY2,
    ST_DX,
    ST_DY,
    ST_CHECK,
    ST_DONE
  } state_e;
endpackage

[rtl/quadratic_bezier_path_stepper_unit.sv]
// quadratic_bezier_path_stepper_unit: control point ring and curve stepper top level
// depends on qbps_pkg
// usage:
//   a request is taken when start is high and busy is low. req_type_i selects
//   a point write, a travel step or a progress reset. point_count is written
//   through cfg_we_i / cfg_wdata_i; the user must write it only while
//   the block is idle, which the block itself does not enforce. each request
//   gives one result: done_o pulses for one cycle with new_x_o, new_y_o,
//   remaining_sqr_o and segment_done_o. the receiver cannot stall. writes,
//   resets and unused types go straight to the done state. a travel step
//   reads the end point and checks reach; each halving then runs on the one
//   shared multiplier (two weight squares, six blend products, two distance
//   squares). busy stays high for the whole request. reset clears the
//   segment index and progress and sets the point count to 16; control
//   points are undefined until written.
`timescale 1ns / 1ps
module quadratic_bezier_path_stepper_unit #(
  parameter int unsigned MAX_POINTS = qbps_pkg::MaxPoints,
  parameter int unsigned PROGRESS_FRAC_BITS = qbps_pkg::ProgFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [4:0]                    cfg_wdata_i,
  input  logic [1:0]                    req_type_i,
  input  logic [3:0]                    point_index_i,
  input  logic signed [23:0]            pos_x_i,
  input  logic signed [23:0]            pos_y_i,
  input  logic [47:0]                   travel_dist_sqr_i,
  output logic                          done_o,
  output logic signed [23:0]            new_x_o,
  output logic signed [23:0]            new_y_o,
  output logic [47:0]                   remaining_sqr_o,
  output logic                          segment_done_o
);
  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned RW = CntW + IdxW;
  localparam int unsigned PW = PROGRESS_FRAC_BITS + 1;
  localparam int unsigned MW = 32;
  localparam int unsigned AccW = 26 + PW + 2;
  localparam logic [PW-1:0] One = PW'(1) << PROGRESS_FRAC_BITS;
  localparam logic [PW-1:0] Half = PW'(1) << (PROGRESS_FRAC_BITS - 1);

  logic [47:0] mem_q [MAX_POINTS];
  logic [47:0] rd_q;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;

  qbps_pkg::state_e state_q, state_d;
  logic [4:0] pcnt_q;
  logic [IdxW-1:0] seg_q, s_q, i1_q, i2_q;
  logic [PW-1:0] prog_q, endp_q;
  logic [4:0] k_q;
  logic [1:0] req_q;
  logic signed [23:0] px_q, py_q, ex_q, ey_q;
  logic [47:0] trav_q;
  logic [48:0] d_q;
  logic [PW-1:0] w0_q, w2_q;
  logic signed [AccW-1:0] acc_q;
  logic [47:0] p0_q, p1_q;

  logic [CntW-1:0] ring;
  always_comb begin
    priority if (pcnt_q < 5'd3) ring = CntW'(3);
    else if (32'(pcnt_q) > MAX_POINTS) ring = CntW'(MAX_POINTS);
    else ring = CntW'(pcnt_q);
  end

  // remainder by shifted compare and subtract
  function automatic logic [IdxW-1:0] wrap(input logic [CntW:0] v, input logic [CntW-1:0] n);
    logic [RW-1:0] r;
    logic [RW-1:0] m;
    r = RW'(v);
    for (int i = IdxW - 1; i >= 0; i--) begin
      m = RW'(n) << i;
      if (r >= m) r = r - m;
    end
    return r[IdxW-1:0];
  endfunction

  // shared multiplier
  logic signed [MW:0] ma, mb;
  logic signed [2*MW+1:0] mp;
  assign mp = ma * mb;

  logic [PW-1:0] u;
  logic [PW:0] wsum;
  logic [PW-1:0] w1;
  logic [PW-1:0] wsel;
  logic signed [23:0] csel;
  logic signed [24:0] diff;
  assign u = One - endp_q;
  assign wsum = {1'b0, w0_q} + {1'b0, w2_q};
  assign w1 = (wsum <= {1'b0, One}) ? PW'({1'b0, One} - wsum) : '0;

  always_comb begin
    wsel = w0_q;
    csel = p0_q[47:24];
    diff = 25'(ex_q) - 25'(px_q);
    ma = '0;
    mb = '0;
    unique case (state_q)
      qbps_pkg::ST_WSQ: begin
        ma = (MW+1)'(u);
        mb = (MW+1)'(u);
      end
      qbps_pkg::ST_W2SQ: begin
        ma = (MW+1)'(endp_q);
        mb = (MW+1)'(endp_q);
      end
      qbps_pkg::ST_BX0, qbps_pkg::ST_BX1, qbps_pkg::ST_BX2,
      qbps_pkg::ST_BY0, qbps_pkg::ST_BY1, qbps_pkg::ST_BY2: begin
        unique case (state_q)
          qbps_pkg::ST_BX0: begin wsel = w0_q; csel = p0_q[47:24]; end
          qbps_pkg::ST_BX1: begin wsel = w1;   csel = p1_q[47:24]; end
          qbps_pkg::ST_BX2: begin wsel = w2_q; csel = rd_q[47:24]; end
          qbps_pkg::ST_BY0: begin wsel = w0_q; csel = p0_q[23:0];  end
          qbps_pkg::ST_BY1: begin wsel = w1;   csel = p1_q[23:0];  end
          default:          begin wsel = w2_q; csel = rd_q[23:0];  end
        endcase
        ma = (MW+1)'(wsel);
        mb = (MW+1)'(csel);
      end
      qbps_pkg::ST_DX, qbps_pkg::ST_END: begin
        diff = 25'(ex_q) - 25'(px_q);
        ma = (MW+1)'(diff);
        mb = (MW+1)'(diff);
      end
      qbps_pkg::ST_DY: begin
        diff = 25'(ey_q) - 25'(py_q);
        ma = (MW+1)'(diff);
        mb = (MW+1)'(diff);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qbps_pkg::ST_IDLE:
        if (start) state_d = (req_type_i == qbps_pkg::REQ_TRAVEL) ? qbps_pkg::ST_RD2
                                                                   : qbps_pkg::ST_DONE;
      qbps_pkg::ST_RD2: state_d = qbps_pkg::ST_END;
      qbps_pkg::ST_END: state_d = qbps_pkg::ST_DY;
      qbps_pkg::ST_HALVE: state_d = qbps_pkg::ST_WSQ;
      qbps_pkg::ST_WSQ: state_d = qbps_pkg::ST_W2SQ;
      qbps_pkg::ST_W2SQ: state_d = qbps_pkg::ST_BX0;
      qbps_pkg::ST_BX0: state_d = qbps_pkg::ST_BX1;
      qbps_pkg::ST_BX1: state_d = qbps_pkg::ST_BX2;
      qbps_pkg::ST_BX2: state_d = qbps_pkg::ST_BY0;
      qbps_pkg::ST_BY0: state_d = qbps_pkg::ST_BY1;
      qbps_pkg::ST_BY1: state_d = qbps_pkg::ST_BY2;
      qbps_pkg::ST_BY2: state_d = qbps_pkg::ST_DX;
      qbps_pkg::ST_DX: state_d = qbps_pkg::ST_DY;
      qbps_pkg::ST_DY: state_d = qbps_pkg::ST_CHECK;
      qbps_pkg::ST_CHECK: begin
        if (k_q == 5'd0 && {1'b0, trav_q} > d_q) state_d = qbps_pkg::ST_DONE;
        else if ({1'b0, trav_q} < d_q && 32'(k_q) < qbps_pkg::HalvingCap)
          state_d = qbps_pkg::ST_HALVE;
        else state_d = qbps_pkg::ST_DONE;
      end
      qbps_pkg::ST_DONE: state_d = qbps_pkg::ST_IDLE;
      default: state_d = qbps_pkg::ST_IDLE;
    endcase
  end

  // memory read address
  always_comb begin
    rd_en = 1'b0;
    rd_addr = i2_q;
    unique case (state_q)
      qbps_pkg::ST_IDLE: begin
        rd_en = 1'b1;
        rd_addr = wrap({1'b0, (CntW)'(seg_q)} + (CntW+1)'(2), ring);
      end
      qbps_pkg::ST_HALVE: begin rd_en = 1'b1; rd_addr = s_q; end
      qbps_pkg::ST_WSQ:   begin rd_en = 1'b1; rd_addr = i1_q; end
      qbps_pkg::ST_W2SQ:  begin rd_en = 1'b1; rd_addr = i2_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[rd_addr];
    if (state_q == qbps_pkg::ST_IDLE && start && req_type_i == qbps_pkg::REQ_WRITE &&
        32'(point_index_i) < MAX_POINTS)
      mem_q[IdxW'(point_index_i)] <= {pos_x_i, pos_y_i};
  end

  logic signed [AccW-1:0] bsum;
  logic signed [AccW-1:0] rnd;
  assign bsum = acc_q + AccW'(mp);
  assign rnd = (bsum + AccW'(Half)) >>> PROGRESS_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qbps_pkg::ST_IDLE;
      pcnt_q <= 5'd16;
      seg_q <= '0;
      prog_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pcnt_q <= cfg_wdata_i;
      unique case (state_q)
        qbps_pkg::ST_IDLE: begin
          if (start) begin
            k_q <= '0;
            if (req_type_i == qbps_pkg::REQ_RESET) begin
              seg_q <= '0;
              prog_q <= '0;
            end
          end
        end
        qbps_pkg::ST_HALVE: k_q <= k_q + 5'd1;
        qbps_pkg::ST_DONE: begin
          if (req_q == qbps_pkg::REQ_TRAVEL) begin
            if (segment_done_o) begin
              seg_q <= i2_q;
              prog_q <= '0;
            end else begin
              seg_q <= s_q;
              prog_q <= endp_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      qbps_pkg::ST_IDLE: begin
        req_q <= req_type_i;
        px_q <= pos_x_i;
        py_q <= pos_y_i;
        trav_q <= travel_dist_sqr_i;
        s_q <= wrap({1'b0, (CntW)'(seg_q)}, ring);
        i1_q <= wrap({1'b0, (CntW)'(seg_q)} + (CntW+1)'(1), ring);
        i2_q <= rd_addr;
        endp_q <= One;
      end
      qbps_pkg::ST_RD2: begin
        ex_q <= rd_q[47:24];
        ey_q <= rd_q[23:0];
      end
      qbps_pkg::ST_END: d_q <= 49'(mp);
      qbps_pkg::ST_HALVE: endp_q <= PW'(({1'b0, prog_q} + {1'b0, endp_q}) >> 1);
      qbps_pkg::ST_WSQ: begin
        w0_q <= PW'((mp + (2*MW+2)'(Half)) >> PROGRESS_FRAC_BITS);
        p0_q <= rd_q;
        acc_q <= '0;
      end
      qbps_pkg::ST_W2SQ: begin
        w2_q <= PW'((mp + (2*MW+2)'(Half)) >> PROGRESS_FRAC_BITS);
        p1_q <= rd_q;
      end
      qbps_pkg::ST_BX0, qbps_pkg::ST_BX1, qbps_pkg::ST_BY0, qbps_pkg::ST_BY1:
        acc_q <= bsum;
      qbps_pkg::ST_BX2: begin ex_q <= 24'(rnd); acc_q <= '0; end
      qbps_pkg::ST_BY2: ey_q <= 24'(rnd);
      qbps_pkg::ST_DX: d_q <= 49'(mp);
      qbps_pkg::ST_DY: d_q <= d_q + 49'(mp);
      default: ;
    endcase
  end

  // results
  logic [48:0] rem;
  assign rem = {1'b0, trav_q} - d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
      segment_done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (state_q == qbps_pkg::ST_CHECK && state_d == qbps_pkg::ST_DONE)
        segment_done_o <= (k_q == 5'd0) && ({1'b0, trav_q} > d_q);
      if (state_q == qbps_pkg::ST_DONE) done_o <= 1'b1;
      if (state_q == qbps_pkg::ST_IDLE && start) segment_done_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == qbps_pkg::ST_IDLE && start) begin
      new_x_o <= '0;
      new_y_o <= '0;
      remaining_sqr_o <= '0;
    end else if (state_q == qbps_pkg::ST_CHECK && state_d == qbps_pkg::ST_DONE) begin
      new_x_o <= ex_q;
      new_y_o <= ey_q;
      remaining_sqr_o <= ({1'b0, trav_q} > d_q) ? rem[47:0] : '0;
    end
  end

  assign busy = (state_q != qbps_pkg::ST_IDLE);

  // result strobe and sequencer state checks
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(k_q) <= qbps_pkg::HalvingCap) else $error("halving count past cap");
  a_seg_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    segment_done_o && done_o |-> k_q == 5'd0) else $error("segment end after halving");
  a_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q <= One) else $error("progress above one");
endmodule
